[rtl/assert_macros.svh]
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/lgsl_pkg.sv]
// types and constants of the grayscale serial loader
package lgsl_pkg;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_FILL  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   // chip geometry
   localparam int          CH_PER_CHIP   = 24;
   localparam int          GRAY_W        = 12;
   localparam logic [4:0]  LAST_CH       = 5'd23;
   localparam logic [3:0]  MSB_POS       = 4'd11;
   localparam logic [8:0]  BITS_PER_CHIP = 9'd288;

   // one request item
   typedef struct packed {
      logic [1:0]        req_type;
      logic              chip;
      logic [4:0]        channel;
      logic [GRAY_W-1:0] gray_value;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic       serial_data;
      logic       shift_strobe;
      logic [1:0] latch_mask;
      logic       busy_res;
   } rsp_item_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic fill_step;
      logic rd_issue;
      logic shift_emit;
   } lgsl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] req_type;
      logic       fill_ok;
      logic       fill_last;
      logic       tick_shift;
   } lgsl_status_type;

endpackage

[rtl/lgsl_ram.sv]
// generic single-write, registered-read ram
module lgsl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/lgsl_ctrl.sv]
// controller state machine of the grayscale serial loader
module lgsl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lgsl_pkg::lgsl_status_type status,
   output logic                     busy,
   output lgsl_pkg::lgsl_cmd_type   cmd
);
   import lgsl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_READ = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.req_type == REQ_FILL && status.fill_ok) begin
               state_in = S_FILL;
            end else if (status.req_type == REQ_TICK && status.tick_shift) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_READ;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.shift_emit = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/lgsl_dp.sv]
// datapath of the grayscale serial loader: store, flags, counters, result register
module lgsl_dp #(
   parameter int CHIPS = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lgsl_pkg::req_item_type    req_data,
   input  lgsl_pkg::lgsl_cmd_type    cmd,
   output lgsl_pkg::lgsl_status_type status,
   output logic                      rsp_valid,
   output lgsl_pkg::rsp_item_type    rsp_data
);
   import lgsl_pkg::*;

   localparam int DEPTH = CHIPS * CH_PER_CHIP;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam logic [AW-1:0] CH_STRIDE = AW'(CH_PER_CHIP);

   req_item_type      req_ff, req_in;
   logic              sending_ff, sending_in;
   logic [CW-1:0]     cur_ff, cur_in;
   logic [8:0]        bit_count_ff, bit_count_in;
   logic [4:0]        ch_ff, ch_in;
   logic [3:0]        bp_ff, bp_in;
   logic [4:0]        fill_count_ff, fill_count_in;
   logic [CHIPS-1:0]  pending_ff, pending_in;
   logic [DEPTH-1:0]  valid_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              chip_ok;
   logic              write_ok;
   logic [CW-1:0]     req_chip;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     fill_addr;
   logic [AW-1:0]     rd_addr;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [GRAY_W-1:0] rdata;
   logic [GRAY_W-1:0] word;
   logic [CW-1:0]     first_pend;
   logic [CW-1:0]     next_pend;
   logic              next_found;

   // request checks and addresses
   assign chip_ok   = (CHIPS > 1) || (req_ff.chip == 1'b0);
   assign write_ok  = !sending_ff && chip_ok && (req_ff.channel <= LAST_CH);
   assign req_chip  = CW'(req_ff.chip);
   assign wr_addr   = AW'(req_ff.chip) * CH_STRIDE + AW'(req_ff.channel);
   assign fill_addr = AW'(req_ff.chip) * CH_STRIDE + AW'(fill_count_ff);
   assign rd_addr   = AW'(cur_ff) * CH_STRIDE + AW'(ch_ff);
   assign word      = rd_ok_ff ? rdata : '0;

   // lowest pending chip, and lowest pending chip above the current one
   always_comb begin
      first_pend = '0;
      next_pend  = '0;
      next_found = 1'b0;
      for (int i = CHIPS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            first_pend = CW'(i);
            if (CW'(i) > cur_ff) begin
               next_pend  = CW'(i);
               next_found = 1'b1;
            end
         end
      end
   end

   // next values of all state
   always_comb begin
      req_in        = req_ff;
      sending_in    = sending_ff;
      cur_in        = cur_ff;
      bit_count_in  = bit_count_ff;
      ch_in         = ch_ff;
      bp_in         = bp_ff;
      fill_count_in = fill_count_ff;
      pending_in    = pending_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      we            = 1'b0;
      waddr         = wr_addr;

      if (cmd.capture) begin
         req_in = req_data;
      end

      // requests finished in the exec state, and ignored ones
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         unique case (req_ff.req_type)
            REQ_WRITE: begin
               if (write_ok) begin
                  we                   = 1'b1;
                  pending_in[req_chip] = 1'b1;
               end
            end
            REQ_START: begin
               if (!sending_ff && (|pending_ff)) begin
                  sending_in   = 1'b1;
                  cur_in       = first_pend;
                  bit_count_in = '0;
                  ch_in        = LAST_CH;
                  bp_in        = MSB_POS;
               end
            end
            REQ_TICK: begin
               // only reached with all bits of the chip sent: latch it
               if (sending_ff) begin
                  if (cur_ff == CW'(0)) begin
                     rsp_in.latch_mask = 2'b01;
                  end else if (cur_ff == CW'(1)) begin
                     rsp_in.latch_mask = 2'b10;
                  end
                  pending_in[cur_ff] = 1'b0;
                  bit_count_in       = '0;
                  ch_in              = LAST_CH;
                  bp_in              = MSB_POS;
                  if (next_found) begin
                     cur_in = next_pend;
                  end else begin
                     sending_in = 1'b0;
                     cur_in     = '0;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp_in.busy_res = sending_in;
      end

      // fill one channel a cycle
      if (cmd.fill_step) begin
         we    = 1'b1;
         waddr = fill_addr;
         if (fill_count_ff == LAST_CH) begin
            fill_count_in        = '0;
            pending_in[req_chip] = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_in.busy_res      = sending_ff;
         end else begin
            fill_count_in = fill_count_ff + 5'd1;
         end
      end

      // word read is under way, note whether the entry was ever written
      if (cmd.rd_issue) begin
         rd_ok_in = valid_ff[rd_addr];
      end

      // shift one bit out
      if (cmd.shift_emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.serial_data  = word[bp_ff];
         rsp_in.shift_strobe = 1'b1;
         rsp_in.busy_res     = sending_ff;
         bit_count_in        = bit_count_ff + 9'd1;
         if (bp_ff == 4'd0) begin
            bp_in = MSB_POS;
            ch_in = ch_ff - 5'd1;
         end else begin
            bp_in = bp_ff - 4'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff    <= 1'b0;
         cur_ff        <= '0;
         bit_count_ff  <= '0;
         ch_ff         <= LAST_CH;
         bp_ff         <= MSB_POS;
         fill_count_ff <= '0;
         pending_ff    <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sending_ff    <= sending_in;
         cur_ff        <= cur_in;
         bit_count_ff  <= bit_count_in;
         ch_ff         <= ch_in;
         bp_ff         <= bp_in;
         fill_count_ff <= fill_count_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rd_ok_ff <= rd_ok_in;
      rsp_ff   <= rsp_in;
   end

   // grayscale store
   lgsl_ram #(
      .WIDTH(GRAY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(waddr),
      .wdata(req_ff.gray_value),
      .raddr(rd_addr),
      .rdata(rdata)
   );

   // status toward the controller
   assign status.req_type   = req_ff.req_type;
   assign status.fill_ok    = !sending_ff && chip_ok;
   assign status.fill_last  = (fill_count_ff == LAST_CH);
   assign status.tick_shift = sending_ff && (bit_count_ff != BITS_PER_CHIP);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/led_grayscale_serial_loader.sv]
// top level of the grayscale serial loader for chained 24-channel LED drivers
//
//   channel    handshake          payload
//   request    start / busy       req_data  (req_type, chip, channel, gray_value)
//   result     rsp_valid strobe   rsp_data  (serial_data, shift_strobe, latch_mask, busy_res)
//
// busy rises in the cycle after an item is taken; the result strobe comes in the
// first cycle with busy low again, and a new item may be taken in that same cycle.
// writes, starts, latching ticks and ignored items are finished in the exec state; a
// shifting tick also passes the read state (registered read of the grayscale ram);
// a fill also passes the fill state, one ram write per channel over the single write port.
// reset is synchronous; all entries read as zero until written (valid bits).
// the result strobe cannot be held off.
module led_grayscale_serial_loader #(
   parameter int CHIPS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lgsl_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output lgsl_pkg::rsp_item_type rsp_data
);
   import lgsl_pkg::*;

   lgsl_cmd_type    cmd;
   lgsl_status_type status;

   // sequencing
   lgsl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .busy  (busy),
      .cmd   (cmd)
   );

   // storage and bit shifting
   lgsl_dp #(
      .CHIPS(CHIPS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/lgsl_checker.sv]
// port-level checks of the grayscale serial loader, bound to its top level
`include "assert_macros.svh"

module lgsl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input lgsl_pkg::rsp_item_type rsp_data
);
   import lgsl_pkg::*;

   // a taken item keeps the block busy in the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a result only follows a busy cycle
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

   // a bit and a latch never go out together
   `ASSERT_SAME(a_shift_no_latch, clock, reset, rsp_valid && rsp_data.shift_strobe,
      rsp_data.latch_mask == 2'b00)

   // shifting only happens during a send
   `ASSERT_SAME(a_shift_sending, clock, reset, rsp_valid && rsp_data.shift_strobe,
      rsp_data.busy_res)

endmodule

bind led_grayscale_serial_loader lgsl_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

[tb/sv/lgsl_checker.sv]
// checker for the grayscale serial loader: predicts every result and compares it
`timescale 1ns / 100ps

module lgsl_scoreboard (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  lgsl_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  lgsl_pkg::rsp_item_type rsp_data,
   output int                     fail_count,
   output int                     outstanding
);
   import lgsl_pkg::*;

   localparam int N_CHIPS = 2;

   // shadow copy of the loader state
   logic [GRAY_W-1:0] gray_mem [N_CHIPS][CH_PER_CHIP];
   logic [N_CHIPS-1:0] chip_pending;
   logic               send_active;
   logic               send_chip;
   logic [8:0]         sent_bits;

   // one entry per accepted item, oldest first
   rsp_item_type       predicted_outputs [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // clear the shadow state
   task automatic clear_shadow();
      for (int c = 0; c < N_CHIPS; c++)
         for (int ch = 0; ch < CH_PER_CHIP; ch++)
            gray_mem[c][ch] = '0;
      chip_pending = '0;
      send_active  = 1'b0;
      send_chip    = 1'b0;
      sent_bits    = '0;
   endtask

   // advance the shadow state by one item and return the result it causes
   function automatic rsp_item_type serial_step(req_item_type it);
      rsp_item_type r;
      int           ch;
      int           bp;
      r = '0;
      case (it.req_type)
         REQ_WRITE: begin
            // writes are dropped while sending or for channels past the last
            if (!send_active && it.channel <= LAST_CH) begin
               gray_mem[it.chip][it.channel] = it.gray_value;
               chip_pending[it.chip] = 1'b1;
            end
         end
         REQ_FILL: begin
            if (!send_active) begin
               for (int k = 0; k < CH_PER_CHIP; k++)
                  gray_mem[it.chip][k] = it.gray_value;
               chip_pending[it.chip] = 1'b1;
            end
         end
         REQ_START: begin
            // start only does something when idle with a chip pending
            if (!send_active && chip_pending != '0) begin
               send_active = 1'b1;
               send_chip   = chip_pending[0] ? 1'b0 : 1'b1;
               sent_bits   = '0;
            end
         end
         default: begin
            if (send_active) begin
               if (sent_bits < BITS_PER_CHIP) begin
                  // msb first, channel 23 down to channel 0
                  ch = int'(LAST_CH) - int'(sent_bits) / GRAY_W;
                  bp = int'(MSB_POS) - int'(sent_bits) % GRAY_W;
                  r.serial_data  = gray_mem[send_chip][ch][bp];
                  r.shift_strobe = 1'b1;
                  sent_bits      = sent_bits + 9'd1;
               end else begin
                  // latch tick, then move on to the next pending chip
                  r.latch_mask[send_chip] = 1'b1;
                  chip_pending[send_chip] = 1'b0;
                  sent_bits = '0;
                  if (send_chip == 1'b0 && chip_pending[1]) begin
                     send_chip = 1'b1;
                  end else begin
                     send_active = 1'b0;
                     send_chip   = 1'b0;
                  end
               end
            end
         end
      endcase
      r.busy_res = send_active;
      return r;
   endfunction

   // print one mismatch line and count it
   task automatic flag(string what, int got, int want);
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // compare results, then predict for the item taken at this edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         clear_shadow();
         predicted_outputs.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_outputs.size() == 0) begin
               flag("result with no item waiting", int'(rsp_data), 0);
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_data.serial_data !== want.serial_data)
                  flag("serial_data", rsp_data.serial_data, want.serial_data);
               if (rsp_data.shift_strobe !== want.shift_strobe)
                  flag("shift_strobe", rsp_data.shift_strobe, want.shift_strobe);
               if (rsp_data.latch_mask !== want.latch_mask)
                  flag("latch_mask", rsp_data.latch_mask, want.latch_mask);
               if (rsp_data.busy_res !== want.busy_res)
                  flag("busy_res", rsp_data.busy_res, want.busy_res);
            end
         end
         if (start && !busy)
            predicted_outputs.push_back(serial_step(req_data));
      end
      outstanding = predicted_outputs.size();
   end

endmodule

[tb/sv/tb.sv]
// testbench top for the grayscale serial loader: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb;
   import lgsl_pkg::*;

   localparam int N_CHIPS    = 2;
   localparam int CHIP_TICKS = int'(BITS_PER_CHIP) + 1;
   localparam int RAND_ITEMS = 750;
   localparam int STALL_MAX  = 4000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   int           fail_count;
   int           outstanding;

   int           items_sent = 0;
   bit           calm = 1'b0;
   int           quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   led_grayscale_serial_loader #(.CHIPS(N_CHIPS)) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   lgsl_scoreboard u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   // watchdog: too long with neither an item nor a result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one item and hold it until the block takes it
   task automatic send_item(req_item_type it);
      int gap;
      if (!calm && $urandom_range(0, 99) < 6) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_fields(logic [1:0] op, logic chip, logic [4:0] channel,
                              logic [GRAY_W-1:0] gray);
      req_item_type it;
      it.req_type   = op;
      it.chip       = chip;
      it.channel    = channel;
      it.gray_value = gray;
      send_item(it);
   endtask

   // hold off until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // grayscale level with extra weight on the extremes
   function automatic logic [GRAY_W-1:0] pick_gray();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return GRAY_W'($urandom_range(0, 4095));
   endfunction

   function automatic req_item_type any_item(int top_op);
      req_item_type it;
      it.req_type   = 2'($urandom_range(0, top_op));
      it.chip       = 1'($urandom_range(0, 1));
      it.channel    = 5'($urandom_range(0, 31));
      it.gray_value = pick_gray();
      return it;
   endfunction

   // load some chips, start a send and tick it through, with stray items mixed in
   task automatic send_sequence();
      int         loads;
      int         ticks;
      logic       chip;
      logic [4:0] channel;
      logic [N_CHIPS-1:0] loaded;
      loaded = '0;
      loads  = $urandom_range(1, 8);
      for (int i = 0; i < loads; i++) begin
         chip = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 30) begin
            send_fields(REQ_FILL, chip, 5'($urandom_range(0, 31)), pick_gray());
            loaded[chip] = 1'b1;
         end else begin
            channel = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 23));
            send_fields(REQ_WRITE, chip, channel, pick_gray());
            if (channel <= LAST_CH) loaded[chip] = 1'b1;
         end
      end
      send_fields(REQ_START, 1'b0, 5'd0, 12'd0);
      ticks = CHIP_TICKS * $countones(loaded) + $urandom_range(0, 2);
      // now and then the send is cut short and runs on into later items
      if ($urandom_range(0, 99) < 15) ticks = $urandom_range(1, ticks);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 99) < 3)
            send_item(any_item(int'(REQ_START)));
         else
            send_fields(REQ_TICK, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                        pick_gray());
      end
   endtask

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle tick, empty start, out of range channels
      send_fields(REQ_TICK,  1'b0, 5'd0,  12'h000);
      send_fields(REQ_START, 1'b0, 5'd0,  12'h000);
      send_fields(REQ_WRITE, 1'b0, 5'd24, 12'hFFF);
      send_fields(REQ_WRITE, 1'b1, 5'd31, 12'hFFF);
      send_fields(REQ_START, 1'b1, 5'd31, 12'hFFF);
      // load both chips
      send_fields(REQ_WRITE, 1'b0, 5'd23, 12'hFFF);
      send_fields(REQ_WRITE, 1'b0, 5'd0,  12'h801);
      send_fields(REQ_WRITE, 1'b0, 5'd12, 12'h000);
      send_fields(REQ_FILL,  1'b1, 5'd7,  12'hAAA);
      send_fields(REQ_WRITE, 1'b1, 5'd0,  12'h555);
      send_fields(REQ_START, 1'b0, 5'd0,  12'h000);
      // everything but ticks is dropped while sending
      send_fields(REQ_START, 1'b1, 5'd0,  12'h000);
      send_fields(REQ_WRITE, 1'b0, 5'd1,  12'hFFF);
      send_fields(REQ_FILL,  1'b1, 5'd0,  12'h000);
      for (int i = 0; i < 2 * CHIP_TICKS + 2; i++)
         send_fields(REQ_TICK, 1'b0, 5'd0, 12'h000);
      // only chip 1 pending
      send_fields(REQ_FILL,  1'b1, 5'd31, 12'h3C3);
      send_fields(REQ_START, 1'b0, 5'd0,  12'h000);
      for (int i = 0; i < CHIP_TICKS + 1; i++)
         send_fields(REQ_TICK, 1'b1, 5'd31, 12'hFFF);
      drain();

      // random part, opening with a long stretch free of sender gaps
      n = items_sent + RAND_ITEMS;
      calm = 1'b1;
      while (items_sent < n - RAND_ITEMS + 300) send_sequence();
      calm = 1'b0;
      while (items_sent < n) begin
         if ($urandom_range(0, 99) < 80) begin
            send_sequence();
         end else begin
            repeat ($urandom_range(4, 30)) send_item(any_item(int'(REQ_TICK)));
         end
         if ($urandom_range(0, 9) == 0) drain();
      end

      // wrap up
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
